// File: sv/rft_pkg.sv
package rft_pkg;

  // Default message buffer depth in bytes.
  localparam int MaxLenDef = 64;

  // Fixed field widths.
  localparam int ByteW = 8;
  localparam int RailW = 7;

  // Configuration port geometry.
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  // Register indexes (byte address is four times the index).
  localparam logic REG_RAIL_COUNT   = 1'b0;
  localparam logic REG_DECRYPT_MODE = 1'b1;

  // Reset values of the registers.
  localparam logic [RailW-1:0] RailCountReset = 7'd2;
  localparam logic             DecryptReset   = 1'b0;

  // Control flags that go with each position pair from the generator.
  typedef struct packed {
    logic valid;
    logic last;
  } gen_ctrl_t;

endpackage

// File: sv/rft_apb_regs.sv
module rft_apb_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rft_pkg::ApbAddrW-1:0]       paddr,
  input  logic [rft_pkg::ApbDataW-1:0]       pwdata,
  output logic [rft_pkg::ApbDataW-1:0]       prdata,
  output logic                               pready,
  output logic [rft_pkg::RailW-1:0]          rail_count,
  output logic                               decrypt_mode
);

  logic reg_index;
  logic wr_en;

  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      rail_count   <= rft_pkg::RailCountReset;
      decrypt_mode <= rft_pkg::DecryptReset;
    end else if (wr_en) begin
      unique case (reg_index)
        rft_pkg::REG_RAIL_COUNT:   rail_count   <= pwdata[rft_pkg::RailW-1:0];
        rft_pkg::REG_DECRYPT_MODE: decrypt_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back of the selected register.
  always_comb begin
    prdata = '0;
    unique case (reg_index)
      rft_pkg::REG_RAIL_COUNT:   prdata = rft_pkg::ApbDataW'(rail_count);
      rft_pkg::REG_DECRYPT_MODE: prdata = rft_pkg::ApbDataW'(decrypt_mode);
      default:                   prdata = '0;
    endcase
  end

endmodule

// File: sv/rft_zigzag_gen.sv
module rft_zigzag_gen #(
  parameter int MAX_LEN = rft_pkg::MaxLenDef
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             bypass,
  input  logic [$clog2(MAX_LEN)-1:0]       rails,
  input  logic [$clog2(MAX_LEN):0]         len,
  output rft_pkg::gen_ctrl_t               ctrl,
  output logic [$clog2(MAX_LEN)-1:0]       k,
  output logic [$clog2(MAX_LEN)-1:0]       pos
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = AW + 1;

  logic          active;
  logic [AW-1:0] rail;
  logic          phase;
  logic          bypass_q;
  logic [AW-1:0] rails_q;
  logic [LW-1:0] len_q;

  logic [AW-1:0] rails_m1;
  logic [LW-1:0] step;
  logic [LW:0]   sum;
  logic          is_last;

  assign rails_m1 = rails_q - AW'(1);
  assign is_last  = (LW'(k) == len_q - LW'(1));

  // Distance to the next position on the current rail: the outer rails
  // repeat once per period, inner rails alternate the down and up legs.
  always_comb begin
    if (rail == AW'(0) || rail == rails_m1) begin
      step = {rails_m1, 1'b0};
    end else if (phase) begin
      step = {rail, 1'b0};
    end else begin
      step = {rails_m1 - rail, 1'b0};
    end
  end

  assign sum = (LW+1)'(pos) + (LW+1)'(step);

  assign ctrl.valid = active;
  assign ctrl.last  = active && is_last;

  // Walk the rails top to bottom, one position per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
    end else if (active && is_last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k        <= '0;
      pos      <= '0;
      rail     <= '0;
      phase    <= 1'b0;
      bypass_q <= bypass;
      rails_q  <= rails;
      len_q    <= len;
    end else if (active && !is_last) begin
      k <= k + AW'(1);
      if (bypass_q) begin
        pos <= pos + AW'(1);
      end else if (sum >= (LW+1)'(len_q)) begin
        rail  <= rail + AW'(1);
        pos   <= rail + AW'(1);
        phase <= 1'b0;
      end else begin
        pos   <= sum[AW-1:0];
        phase <= !phase;
      end
    end
  end

endmodule

// File: sv/rail_fence_transposer.sv
// Rail fence transposer. Message bytes are taken one per cycle into a
// buffer of MAX_LEN bytes; the request with end_of_message set closes the
// message, and bytes beyond MAX_LEN are dropped and reported through
// overflowed on every output byte of that message. After the last byte the
// block accepts no request until the whole message is delivered: a setup
// state, then a shared position generator walks the zigzag and moves each
// stored byte from the message buffer into the result buffer, a drain
// state finishes the last move, then each output byte takes a result buffer
// read and the output register, and waits while out_ready is low.
// rail_count and decrypt_mode must be written over the APB port only while
// the block is idle; the block itself does not enforce this. A rail count
// of one or less, or a message no longer than the rail count, passes the
// text through unchanged.
module rail_fence_transposer #(
  parameter int MAX_LEN = rft_pkg::MaxLenDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rft_pkg::ApbAddrW-1:0]  paddr,
  input  logic [rft_pkg::ApbDataW-1:0]  pwdata,
  output logic [rft_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rft_pkg::ByteW-1:0]     text_byte,
  input  logic                          end_of_message,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rft_pkg::ByteW-1:0]     result_byte,
  output logic                          final_byte,
  output logic                          overflowed
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = AW + 1;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_PERM  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_SHOW  = 3'd5;

  logic [2:0]                 state;
  logic [2:0]                 state_next;
  logic [LW-1:0]              len_cnt;
  logic                       dropped;
  logic [AW-1:0]              emit_idx;

  logic [rft_pkg::RailW-1:0]  rail_count;
  logic                       decrypt_mode;

  rft_pkg::gen_ctrl_t         gen_ctrl;
  logic [AW-1:0]              gen_k;
  logic [AW-1:0]              gen_pos;
  logic                       bypass;

  logic [rft_pkg::ByteW-1:0]  msg_mem [MAX_LEN];
  logic [rft_pkg::ByteW-1:0]  res_mem [MAX_LEN];
  logic [rft_pkg::ByteW-1:0]  msg_q;
  logic [rft_pkg::ByteW-1:0]  res_q;
  logic                       wr_pending;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;

  logic                       in_take;
  logic                       out_take;
  logic                       buf_full;
  logic                       emit_last;

  rft_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .rail_count   (rail_count),
    .decrypt_mode (decrypt_mode)
  );

  // Pass-through when there is no zigzag to speak of.
  assign bypass = (rail_count <= rft_pkg::RailW'(1)) ||
                  (rft_pkg::RailW'(len_cnt) <= rail_count);

  rft_zigzag_gen #(
    .MAX_LEN (MAX_LEN)
  ) u_gen (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_START),
    .bypass (bypass),
    .rails  (rail_count[AW-1:0]),
    .len    (len_cnt),
    .ctrl   (gen_ctrl),
    .k      (gen_k),
    .pos    (gen_pos)
  );

  assign in_ready  = (state == S_LOAD);
  assign in_take   = in_valid && in_ready;
  assign out_valid = (state == S_SHOW);
  assign out_take  = out_valid && out_ready;
  assign buf_full  = (len_cnt == LW'(MAX_LEN));
  assign emit_last = (LW'(emit_idx) == len_cnt - LW'(1));

  assign result_byte = res_q;
  assign final_byte  = emit_last;
  assign overflowed  = dropped;

  // Sequencer: load, permute, emit.
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:  if (in_take && end_of_message) state_next = S_START;
      S_START: state_next = S_PERM;
      S_PERM:  if (gen_ctrl.last) state_next = S_DRAIN;
      S_DRAIN: state_next = S_RD;
      S_RD:    state_next = S_SHOW;
      S_SHOW:  if (out_take) state_next = emit_last ? S_LOAD : S_RD;
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Stored length and overflow flag, cleared once the message is out.
  always_ff @(posedge clk) begin
    if (rst) begin
      len_cnt <= '0;
      dropped <= 1'b0;
    end else if (in_take) begin
      if (buf_full) begin
        dropped <= 1'b1;
      end else begin
        len_cnt <= len_cnt + LW'(1);
      end
    end else if (out_take && emit_last) begin
      len_cnt <= '0;
      dropped <= 1'b0;
    end
  end

  // Message buffer: written while loading, read by the permutation.
  // Encryption gathers from the zigzag position, decryption scatters to it.
  assign rd_addr = decrypt_mode ? gen_k : gen_pos;

  always_ff @(posedge clk) begin
    if (in_take && !buf_full) begin
      msg_mem[len_cnt[AW-1:0]] <= text_byte;
    end
    msg_q <= msg_mem[rd_addr];
  end

  // The write into the result buffer comes in the cycle after the message buffer read.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pending <= 1'b0;
    end else begin
      wr_pending <= gen_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= decrypt_mode ? gen_pos : gen_k;
  end

  // Result buffer: filled by the permutation, read out in order.
  always_ff @(posedge clk) begin
    if (wr_pending) begin
      res_mem[wr_addr] <= msg_q;
    end
    if (state == S_RD) begin
      res_q <= res_mem[emit_idx];
    end
  end

  // Output position counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx <= '0;
    end else if (state == S_START) begin
      emit_idx <= '0;
    end else if (out_take) begin
      emit_idx <= emit_idx + AW'(1);
    end
  end

endmodule

// File: test/rail_fence_monitor.sv
`timescale 1ns / 1ps

// Watches the register port and both request channels of the transposer.
// It rebuilds each message on its own and queues the characters that the
// block must return. It then compares every returned character in order.
module rail_fence_monitor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [rft_pkg::ApbAddrW-1:0] paddr,
  input  logic [rft_pkg::ApbDataW-1:0] pwdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [rft_pkg::ByteW-1:0]    text_byte,
  input  logic                         end_of_message,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [rft_pkg::ByteW-1:0]    result_byte,
  input  logic                         final_byte,
  input  logic                         overflowed,
  output int                           mismatches,
  output int                           outstanding
);

  localparam int MsgCap = rft_pkg::MaxLenDef;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [rft_pkg::ByteW-1:0] data;
    logic                      last;
    logic                      ovf;
  } text_char_t;

  // Characters still owed by the block, oldest first.
  text_char_t awaited_chars[$];

  // Shadow copy of the message under construction and of the registers.
  logic [rft_pkg::ByteW-1:0] msg_buf [MsgCap];
  int                        msg_len = 0;
  logic                      drop_seen = 1'b0;
  logic [rft_pkg::RailW-1:0] rails = rft_pkg::RailCountReset;
  logic                      decrypt = rft_pkg::DecryptReset;
  int                        errs = 0;
  int                        char_idx = 0;

  // Closes the current message: works out the zigzag permutation and queues
  // one character per stored byte.
  task automatic emit_transposed();
    logic [rft_pkg::ByteW-1:0] res [MsgCap];
    int         order [MsgCap];
    int         n, r, i, k, m, period, nrails;
    text_char_t c;
    nrails = int'(rails);
    if (nrails <= 1 || msg_len <= nrails) begin
      // Too few rails or a message no longer than the rail count passes through.
      for (i = 0; i < msg_len; i++) res[i] = msg_buf[i];
    end else begin
      // List the message positions rail by rail, top rail first.
      period = 2 * (nrails - 1);
      n = 0;
      for (r = 0; r < nrails; r++) begin
        for (i = 0; i < msg_len; i++) begin
          m = i % period;
          if (((m < nrails) ? m : period - m) == r) begin
            order[n] = i;
            n++;
          end
        end
      end
      // Encryption reads along that list; decryption scatters back along it.
      for (k = 0; k < msg_len; k++) begin
        if (decrypt) res[order[k]] = msg_buf[k];
        else res[k] = msg_buf[order[k]];
      end
    end
    for (k = 0; k < msg_len; k++) begin
      c.data = res[k];
      c.last = (k == msg_len - 1);
      c.ovf  = drop_seen;
      awaited_chars.push_back(c);
    end
    msg_len = 0;
    drop_seen = 1'b0;
  endtask

  always @(posedge clk) begin
    text_char_t got, want;
    if (rst) begin
      awaited_chars.delete();
      msg_len = 0;
      drop_seen = 1'b0;
      rails = rft_pkg::RailCountReset;
      decrypt = rft_pkg::DecryptReset;
    end else begin
      // Compare a returned character with the oldest one owed.
      if (out_valid && out_ready) begin
        got = {result_byte, final_byte, overflowed};
        if (awaited_chars.size() == 0) begin
          errs++;
          if (errs <= ReportLimit) begin
            $display("unexpected character %0d: byte %02h final %0b overflow %0b",
                     char_idx, got.data, got.last, got.ovf);
          end
        end else begin
          want = awaited_chars.pop_front();
          if (got !== want) begin
            errs++;
            if (errs <= ReportLimit) begin
              $display("character %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                       char_idx, want.data, want.last, want.ovf,
                       got.data, got.last, got.ovf);
            end
          end
        end
        char_idx++;
      end

      // Track register writes; an unknown index is ignored.
      if (psel && penable && pwrite && pready) begin
        if (paddr[rft_pkg::ApbAddrW-1:2] == rft_pkg::REG_RAIL_COUNT) begin
          rails = pwdata[rft_pkg::RailW-1:0];
        end else if (paddr[rft_pkg::ApbAddrW-1:2] == rft_pkg::REG_DECRYPT_MODE) begin
          decrypt = pwdata[0];
        end
      end

      // Store an accepted byte, or note the drop once the buffer is full.
      if (in_valid && in_ready) begin
        if (msg_len < MsgCap) begin
          msg_buf[msg_len] = text_byte;
          msg_len++;
        end else begin
          drop_seen = 1'b1;
        end
        if (end_of_message) emit_transposed();
      end
    end
    mismatches  <= errs;
    outstanding <= awaited_chars.size();
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int RandomItems = 240;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = 12;
  localparam int TailCycles = 40;
  localparam int CycleLimit = 600000;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [rft_pkg::ApbAddrW-1:0] paddr = '0;
  logic [rft_pkg::ApbDataW-1:0] pwdata = '0;
  logic [rft_pkg::ApbDataW-1:0] prdata;
  logic                         pready;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [rft_pkg::ByteW-1:0]    text_byte = '0;
  logic                         end_of_message = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [rft_pkg::ByteW-1:0]    result_byte;
  logic                         final_byte;
  logic                         overflowed;

  int   mismatches;
  int   outstanding;
  int   sent_count = 0;
  int   hold_asks = 0;
  int   hold_done = 0;
  logic tx_quiet = 1'b0;

  rail_fence_transposer DUT (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .text_byte      (text_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_byte    (result_byte),
    .final_byte     (final_byte),
    .overflowed     (overflowed)
  );

  rail_fence_monitor u_monitor (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .text_byte      (text_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_byte    (result_byte),
    .final_byte     (final_byte),
    .overflowed     (overflowed),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle stretch length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Rail counts lean toward the edges: pass through, the buffer size and the
  // largest value the register holds.
  function automatic logic [rft_pkg::RailW-1:0] pick_rails();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return rft_pkg::RailW'(0);
      1: return rft_pkg::RailW'(1);
      2: return rft_pkg::RailW'(127);
      3: return rft_pkg::RailW'(rft_pkg::MaxLenDef);
      4: return rft_pkg::RailW'(rft_pkg::MaxLenDef - 1);
      default: return rft_pkg::RailW'($urandom_range(2, 12));
    endcase
  endfunction

  // Message lengths are mostly short, some fill most of the buffer, and a
  // few reach or run past it.
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 16);
    if (r < 18) return $urandom_range(17, rft_pkg::MaxLenDef - 1);
    return $urandom_range(rft_pkg::MaxLenDef, rft_pkg::MaxLenDef + 8);
  endfunction

  // One register write: a setup phase, then access until pready.
  task automatic reg_write(input logic idx, input logic [rft_pkg::ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rft_pkg::ApbAddrW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every owed character is back and the block has gone quiet,
  // then loads both registers. Upper data bits are random noise.
  task automatic reconfigure(input logic [rft_pkg::RailW-1:0] rails_val,
                             input logic dec_val);
    logic [rft_pkg::ApbDataW-1:0] word;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    word = $urandom();
    word[rft_pkg::RailW-1:0] = rails_val;
    reg_write(rft_pkg::REG_RAIL_COUNT, word);
    word = $urandom();
    word[0] = dec_val;
    reg_write(rft_pkg::REG_DECRYPT_MODE, word);
  endtask

  // Offers one request and holds it until it is accepted. Valid stays high
  // into the next request when there is no gap.
  task automatic send_req(input logic [rft_pkg::ByteW-1:0] b, input logic eom);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    text_byte      <= b;
    end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_message(input int len);
    int i;
    for (i = 0; i < len; i++) begin
      send_req(rft_pkg::ByteW'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Result side: random stalls, long stretches without any, and a long
  // hold-off whenever the stimulus asks for one.
  initial begin : receiver
    int busy, gap;
    @(posedge clk);
    forever begin
      if (hold_done != hold_asks) begin
        hold_done = hold_asks;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        busy = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
        out_ready <= 1'b1;
        repeat (busy) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Ends a run that hangs.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("rail_fence_transposer: mismatch");
    $finish;
  end

  initial begin : stimulus
    int i, base, msgs, len;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings: two rails, encryption. A single byte
    // is a short message; the next one takes a real zigzag.
    send_req(8'h00, 1'b1);
    send_req(8'hFF, 1'b0);
    send_req(8'h55, 1'b0);
    send_req(8'hAA, 1'b1);

    // Three rails in decryption.
    reconfigure(7'd3, 1'b1);
    for (i = 1; i <= 6; i++) send_req(rft_pkg::ByteW'(i * 8'h11), i == 6);

    // Zero and one rail pass the text through in both modes.
    reconfigure(7'd0, 1'b0);
    send_req(8'h12, 1'b0);
    send_req(8'h34, 1'b1);
    reconfigure(7'd1, 1'b1);
    send_req(8'h9A, 1'b0);
    send_req(8'hBC, 1'b0);
    send_req(8'hDE, 1'b1);

    // The largest rail count, and a message exactly as long as the rails.
    reconfigure(7'd127, 1'b1);
    send_req(8'hA5, 1'b0);
    send_req(8'h5A, 1'b1);
    reconfigure(7'd4, 1'b0);
    send_req(8'h0F, 1'b0);
    send_req(8'hF0, 1'b0);
    send_req(8'h3C, 1'b0);
    send_req(8'hC3, 1'b1);

    // Random part: new settings per phase, a few messages per phase. The
    // first messages hit a last byte dropped at a full buffer, an exactly
    // full buffer, and several dropped bytes.
    base = sent_count;
    msgs = 0;
    while (sent_count - base < RandomItems) begin
      reconfigure(pick_rails(), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 3)) begin
        if (msgs == 0 || $urandom_range(0, 11) == 0) hold_asks++;
        tx_quiet = ($urandom_range(0, 3) == 0);
        if (msgs == 0) len = rft_pkg::MaxLenDef + 1;
        else if (msgs == 1) len = rft_pkg::MaxLenDef;
        else if (msgs == 2) len = rft_pkg::MaxLenDef + 6;
        else len = pick_length();
        send_message(len);
        msgs++;
      end
    end

    // Drain and give the verdict.
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("rail_fence_transposer: match");
    end else begin
      $display("rail_fence_transposer: mismatch");
    end
    $finish;
  end

endmodule
